[rtl/core/apfm_pkg.sv]
package apfm_pkg;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned BIT_W  = $clog2(DATA_W);

  // Configuration register indexes
  localparam logic REG_FREQ_SCALE = 1'b0;
  localparam logic REG_CAL_OFFSET = 1'b1;

  // Input command codes
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAPT,
    ST_DIV,
    ST_HOLD
  } apfm_state_t;

  // Serial accumulator sequencer
  typedef enum logic [1:0] {
    ACC_IDLE,
    ACC_RUN,
    ACC_FIN
  } apfm_acc_state_t;

  // Accumulator status toward the top level
  typedef struct packed {
    logic busy;
    logic batch_done;
  } apfm_acc_stat_t;

endpackage

[rtl/core/apfm_accum.sv]
module apfm_accum #(
  parameter int unsigned AVG_SAMPLES = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [apfm_pkg::DATA_W-1:0]  capture_time,
  output logic [apfm_pkg::DATA_W-1:0]  latched_sum,
  output apfm_pkg::apfm_acc_stat_t     stat
);
  import apfm_pkg::*;

  apfm_acc_state_t   state;
  apfm_acc_state_t   state_next;
  logic [DATA_W-1:0] t_sr;
  logic [DATA_W-1:0] prev_sr;
  logic [DATA_W-1:0] acc_sr;
  logic [BIT_W-1:0]  bit_cnt;
  logic [CNT_W-1:0]  count;
  logic              seeded;
  logic              borrow;
  logic              carry;
  logic              d_bit;
  logic              borrow_next;
  logic              s_bit;
  logic              carry_next;
  logic [CNT_W:0]    count_inc;
  logic              batch_end;

  // One bit of period = t - prev, then one bit of acc + period
  always_comb begin
    d_bit       = t_sr[0] ^ prev_sr[0] ^ borrow;
    borrow_next = (~t_sr[0] & (prev_sr[0] | borrow)) | (prev_sr[0] & borrow);
    s_bit       = acc_sr[0] ^ d_bit ^ carry;
    carry_next  = (acc_sr[0] & d_bit) | (acc_sr[0] & carry) | (d_bit & carry);
    count_inc   = {1'b0, count} + (CNT_W+1)'(1);
    batch_end   = (count_inc >= (CNT_W+1)'(AVG_SAMPLES));
  end

  // Next state and status
  always_comb begin
    state_next      = state;
    stat.busy       = (state != ACC_IDLE);
    stat.batch_done = 1'b0;
    case (state)
      ACC_IDLE: begin
        if (start && seeded) begin
          state_next = ACC_RUN;
        end
      end
      ACC_RUN: begin
        if (bit_cnt == BIT_W'(DATA_W - 1)) begin
          state_next = ACC_FIN;
        end
      end
      ACC_FIN: begin
        stat.batch_done = batch_end;
        state_next      = ACC_IDLE;
      end
      default: state_next = ACC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ACC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Serial datapath: LSB first, new bits enter at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded      <= 1'b0;
      count       <= '0;
      acc_sr      <= '0;
      latched_sum <= '0;
    end else begin
      case (state)
        ACC_IDLE: begin
          if (start) begin
            if (!seeded) begin
              prev_sr <= capture_time;
              seeded  <= 1'b1;
            end else begin
              t_sr    <= capture_time;
              bit_cnt <= '0;
              borrow  <= 1'b0;
              carry   <= 1'b0;
            end
          end
        end
        ACC_RUN: begin
          t_sr    <= t_sr >> 1;
          prev_sr <= {t_sr[0], prev_sr[DATA_W-1:1]};
          acc_sr  <= {s_bit, acc_sr[DATA_W-1:1]};
          borrow  <= borrow_next;
          carry   <= carry_next;
          bit_cnt <= bit_cnt + BIT_W'(1);
        end
        ACC_FIN: begin
          // Close the batch or advance the period count
          if (batch_end) begin
            latched_sum <= acc_sr;
            acc_sr      <= '0;
            count       <= '0;
            seeded      <= 1'b0;
          end else begin
            count <= count_inc[CNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/apfm_div.sv]
module apfm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [apfm_pkg::DATA_W-1:0] dividend,
  input  logic [apfm_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [apfm_pkg::OUT_W-1:0]  quotient
);
  import apfm_pkg::*;

  logic                busy;
  logic [BIT_W-1:0]    step;
  logic [DATA_W-1:0]   dvd_sr;
  logic [DATA_W-1:0]   dvs;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W:0]     shifted;
  logic [DATA_W+1:0]   diff;
  logic                fits;

  // One restoring step: shift in a dividend bit, try the subtract
  always_comb begin
    shifted = {rem, dvd_sr[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    fits    = ~diff[DATA_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == BIT_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient bits come MSB first; only the low bits are kept
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sr <= dividend;
      dvs    <= divisor;
      rem    <= '0;
      step   <= '0;
    end else if (busy) begin
      dvd_sr   <= dvd_sr << 1;
      rem      <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quotient <= {quotient[OUT_W-2:0], fits};
      step     <= step + BIT_W'(1);
    end
  end

endmodule

[rtl/core/averaged_period_frequency_meter_unit.sv]
// Averaged period frequency meter. Each transaction on the input channel is
// either a capture (cmd 0, timer value at a signal edge) or a read (cmd 1).
// Captures build a batch of AVG_SAMPLES periods; the first capture of every
// batch only sets the reference. A read returns freq_scale divided by the
// latched period sum, plus cal_offset, modulo 2^16, or 0 when no new batch
// has arrived since the last read or the sum is zero. Periods are summed
// bit-serially: a capture stalls the input through setup, 32 serial bit
// steps and wrap-up; a reseeding capture only stores the reference. A read
// that divides stalls it while the 32-step restoring divider makes one
// quotient bit per cycle; a read answered with 0 only waits until the
// output register is free. A finished result waits in the output register,
// and captures are taken meanwhile; a second read holds until it is taken.
module averaged_period_frequency_meter_unit #(
  parameter int unsigned AVG_SAMPLES = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [apfm_pkg::DATA_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [apfm_pkg::DATA_W-1:0] capture_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [apfm_pkg::OUT_W-1:0]  frequency
);
  import apfm_pkg::*;

  apfm_state_t              state;
  apfm_state_t              state_next;
  logic [DATA_W-1:0]        freq_scale;
  logic signed [OFS_W-1:0]  cal_offset;
  logic                     batch_fresh;
  logic [OUT_W-1:0]         res;
  logic                     in_accept;
  logic                     acc_start;
  logic                     div_start;
  logic                     out_load;
  logic [DATA_W-1:0]        latched_sum;
  apfm_acc_stat_t           acc_stat;
  logic                     div_done;
  logic [OUT_W-1:0]         quotient;

  apfm_accum #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .start        (acc_start),
    .capture_time (capture_time),
    .latched_sum  (latched_sum),
    .stat         (acc_stat)
  );

  apfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (freq_scale),
    .divisor  (latched_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_scale <= '0;
      cal_offset <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FREQ_SCALE: freq_scale <= cfg_data;
        REG_CAL_OFFSET: cal_offset <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    in_accept  = in_valid && (state == ST_IDLE);
    acc_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_CAPTURE) begin
            acc_start  = 1'b1;
            state_next = ST_CAPT;
          end else if (batch_fresh && latched_sum != '0) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_CAPT: begin
        if (!acc_stat.busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fresh-batch flag: set when a batch closes, clear on any read
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_fresh <= 1'b0;
    end else if (acc_stat.batch_done) begin
      batch_fresh <= 1'b1;
    end else if (in_accept && cmd == CMD_READ) begin
      batch_fresh <= 1'b0;
    end
  end

  // Pending result: zero for empty reads, quotient plus offset otherwise
  always_ff @(posedge clk) begin
    if (in_accept && cmd == CMD_READ) begin
      res <= '0;
    end else if (state == ST_DIV && div_done) begin
      res <= quotient + OUT_W'(cal_offset);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frequency <= res;
    end
  end

endmodule
